@@ hw/rtl/graph_m_coloring_backtrack_core_macros.svh @@
// Assertion macros shared by the graph colouring core
`ifndef GRAPH_M_COLORING_BACKTRACK_CORE_MACROS_SVH
`define GRAPH_M_COLORING_BACKTRACK_CORE_MACROS_SVH

// Condition must hold in the same cycle as the trigger
`define GMC_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition must hold in the cycle after the trigger
`define GMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/gmc_pkg.sv @@
// Package: widths, microcode codes, control word layout and the microprogram
`default_nettype none

package gmc_pkg;

    // Field and datapath widths
    localparam int NODE_W   = 5;
    localparam int COLOR_W  = 5;
    localparam int TRY_W    = 6;
    localparam int ROW_W    = 16;
    localparam int ROWIDX_W = 4;
    localparam int OUTN_W   = 4;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Register indexes (paddr[2])
    localparam logic REG_NUM_COLORS = 1'b0;
    localparam logic REG_NUM_NODES  = 1'b1;

    // Operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Microprogram steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] S_NODE  = 3'd1;
    localparam logic [STEP_W-1:0] S_RANGE = 3'd2;
    localparam logic [STEP_W-1:0] S_FIT   = 3'd3;
    localparam logic [STEP_W-1:0] S_BACK  = 3'd4;
    localparam logic [STEP_W-1:0] S_EMIT  = 3'd5;
    localparam logic [STEP_W-1:0] S_FAIL  = 3'd6;

    // Jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] C_TRUE    = 3'd0;
    localparam logic [COND_W-1:0] C_SEARCH  = 3'd1;
    localparam logic [COND_W-1:0] C_END     = 3'd2;
    localparam logic [COND_W-1:0] C_OVER    = 3'd3;
    localparam logic [COND_W-1:0] C_FITS    = 3'd4;
    localparam logic [COND_W-1:0] C_VZERO   = 3'd5;
    localparam logic [COND_W-1:0] C_LASTOUT = 3'd6;
    localparam logic [COND_W-1:0] C_SLOT    = 3'd7;

    // Datapath actions
    localparam int ACT_W = 4;
    localparam logic [ACT_W-1:0] A_NONE     = 4'd0;
    localparam logic [ACT_W-1:0] A_START    = 4'd1;
    localparam logic [ACT_W-1:0] A_LOAD_ROW = 4'd2;
    localparam logic [ACT_W-1:0] A_LOAD_C   = 4'd3;
    localparam logic [ACT_W-1:0] A_PLACE    = 4'd4;
    localparam logic [ACT_W-1:0] A_NEXT_C   = 4'd5;
    localparam logic [ACT_W-1:0] A_BACK     = 4'd6;
    localparam logic [ACT_W-1:0] A_CLEAR    = 4'd7;
    localparam logic [ACT_W-1:0] A_ZERO_V   = 4'd8;
    localparam logic [ACT_W-1:0] A_EMIT     = 4'd9;
    localparam logic [ACT_W-1:0] A_FAIL     = 4'd10;

    // Control word: one condition, an action and target for each outcome
    typedef struct packed {
        logic [COND_W-1:0] cond;
        logic [ACT_W-1:0]  act_t;
        logic [STEP_W-1:0] tgt_t;
        logic [ACT_W-1:0]  act_f;
        logic [STEP_W-1:0] tgt_f;
    } t_uword;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic search_req;
        logic at_end;
        logic over;
        logic fits;
        logic v_zero;
        logic last_out;
        logic slot_free;
    } t_flags;

    // Microprogram ROM
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            S_IDLE:  w = '{C_SEARCH,  A_START,  S_NODE, A_LOAD_ROW, S_IDLE};
            S_NODE:  w = '{C_END,     A_ZERO_V, S_EMIT, A_LOAD_C,   S_RANGE};
            S_RANGE: w = '{C_OVER,    A_NONE,   S_BACK, A_NONE,     S_FIT};
            S_FIT:   w = '{C_FITS,    A_PLACE,  S_NODE, A_NEXT_C,   S_RANGE};
            S_BACK:  w = '{C_VZERO,   A_CLEAR,  S_FAIL, A_BACK,     S_NODE};
            S_EMIT:  w = '{C_LASTOUT, A_EMIT,   S_IDLE, A_EMIT,     S_EMIT};
            S_FAIL:  w = '{C_SLOT,    A_FAIL,   S_IDLE, A_NONE,     S_FAIL};
            default: w = '{C_TRUE,    A_NONE,   S_IDLE, A_NONE,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gmc_in_if.sv @@
// Input channel: adjacency row loads and search starts
`default_nettype none

interface gmc_in_if import gmc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                operation;
    logic [ROWIDX_W-1:0] row_index;
    logic [ROW_W-1:0]    row_bits;

    modport source (output valid, output operation, output row_index,
                    output row_bits, input ready);
    modport sink   (input valid, input operation, input row_index,
                    input row_bits, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gmc_out_if.sv @@
// Output channel: per-node colours or a failure report
`default_nettype none

interface gmc_out_if import gmc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OUTN_W-1:0]  node;
    logic [COLOR_W-1:0] color;
    logic               found;
    logic               last;

    modport source (output valid, output node, output color, output found,
                    output last, input ready);
    modport sink   (input valid, input node, input color, input found,
                    input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gmc_useq.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps
`default_nettype none

module gmc_useq import gmc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_flags            i_flags,
    output logic [STEP_W-1:0]      o_step,
    output logic [ACT_W-1:0]       o_act
);

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            w_word;
    logic              w_take;

    // Fetch the control word for the current step
    assign w_word = ucode(r_step);

    // Select the jump condition
    always_comb begin
        case (w_word.cond)
            C_TRUE:    w_take = 1'b1;
            C_SEARCH:  w_take = i_flags.search_req;
            C_END:     w_take = i_flags.at_end;
            C_OVER:    w_take = i_flags.over;
            C_FITS:    w_take = i_flags.fits;
            C_VZERO:   w_take = i_flags.v_zero;
            C_LASTOUT: w_take = i_flags.last_out;
            C_SLOT:    w_take = i_flags.slot_free;
            default:   w_take = 1'b1;
        endcase
    end

    // Branch and issue the action
    always_comb begin
        n_step = w_take ? w_word.tgt_t : w_word.tgt_f;
        o_act  = w_take ? w_word.act_t : w_word.act_f;
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_step = r_step;

endmodule

`default_nettype wire

@@ hw/rtl/graph_m_coloring_backtrack_core.sv @@
// Graph m-colouring core: adjacency store, backtracking datapath, output register
//
// Input channel i_in: operation 0 loads row_bits as the adjacency row of node
// row_index (rows at or above the node capacity are dropped); operation 1 starts
// a colouring search over nodes 0 .. n-1 (n is num_nodes clamped to 1 .. the
// capacity) with colours 1 .. num_colors. Output channel o_out: on success one
// transaction per node in order with found=1 and last on the final node; on
// failure one transaction with node=0, color=0, found=0, last=1. Registers
// num_colors (0x0) and num_nodes (0x4) sit on the APB port and are to be
// written only while the core is idle; the core does not enforce this.
// A search runs as a microprogram: each node visit, each colour tried (range
// check, then fit check), each backtrack step (the failed range check and the
// step back) and each reported node is a step of the sequencer, so its length
// depends on the graph and may grow exponentially with the node count. The
// neighbour check compares all node colours in parallel, so each trial costs the same.
// A new transaction is taken only when the sequencer is back in its idle step;
// the final result may still wait in the output register while it does.
// A stalled receiver holds the sequencer in its reporting step.
// Reset clears the sequencer, the colour store and the registers (num_colors
// 3, num_nodes 16); adjacency rows hold nothing defined until loaded.
`default_nettype none
`include "graph_m_coloring_backtrack_core_macros.svh"

module graph_m_coloring_backtrack_core import gmc_pkg::*; #(
    parameter int MAX_NODES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    gmc_in_if.sink                 i_in,
    gmc_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int ROWS  = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
    localparam int IDX_W = $clog2(ROWS);

    // Storage
    logic [ROW_W-1:0]   r_adj   [ROWS];
    logic [COLOR_W-1:0] r_color [ROWS];

    // Search registers
    logic [NODE_W-1:0]  r_v, n_v;
    logic [TRY_W-1:0]   r_try, n_try;
    logic [NODE_W-1:0]  r_count, n_count;
    logic [COLOR_W-1:0] r_num_colors;
    logic [NODE_W-1:0]  r_num_nodes;

    // Output register
    logic               r_out_valid, n_out_valid;
    logic [OUTN_W-1:0]  r_out_node, n_out_node;
    logic [COLOR_W-1:0] r_out_color, n_out_color;
    logic               r_out_found, n_out_found;
    logic               r_out_last, n_out_last;

    logic [STEP_W-1:0]  w_step;
    logic [ACT_W-1:0]   w_act;
    t_flags             w_flags;
    logic               w_in_acc;
    logic               w_cfg_wr;
    logic [IDX_W-1:0]   w_vidx;
    logic [ROW_W-1:0]   w_row;
    logic               w_hit;
    logic [NODE_W-1:0]  w_clamped;
    logic               w_push;
    logic               w_emit_last;
    logic               w_busy;
    logic               w_placing;
    logic               w_place_ok;
    logic               w_fail_out;
    logic               w_fail_ok;

    // Sequencer
    gmc_useq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_step  (w_step),
        .o_act   (w_act)
    );

    // Handshakes
    assign i_in.ready = (w_step == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;

    // Register read back
    always_comb begin
        case (paddr[2])
            REG_NUM_COLORS: prdata = {{(APB_DW-COLOR_W){1'b0}}, r_num_colors};
            REG_NUM_NODES:  prdata = {{(APB_DW-NODE_W){1'b0}}, r_num_nodes};
            default:        prdata = '0;
        endcase
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_colors <= COLOR_W'(3);
            r_num_nodes  <= NODE_W'(16);
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_NUM_COLORS: r_num_colors <= pwdata[COLOR_W-1:0];
                REG_NUM_NODES:  r_num_nodes  <= pwdata[NODE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamp the node count to 1 .. capacity
    always_comb begin
        if (r_num_nodes == '0) begin
            w_clamped = NODE_W'(1);
        end else if (r_num_nodes > NODE_W'(ROWS)) begin
            w_clamped = NODE_W'(ROWS);
        end else begin
            w_clamped = r_num_nodes;
        end
    end

    // Neighbour check: any neighbour in range holding the trial colour
    assign w_vidx = r_v[IDX_W-1:0];
    assign w_row  = r_adj[w_vidx];

    always_comb begin
        w_hit = 1'b0;
        for (int i = 0; i < ROWS; i++) begin
            if (w_row[i] && (NODE_W'(i) < r_count)
                && ({1'b0, r_color[i]} == r_try)) begin
                w_hit = 1'b1;
            end
        end
    end

    assign w_emit_last = (r_v == (r_count - NODE_W'(1)));

    // Flags for the sequencer
    always_comb begin
        w_flags.search_req = w_in_acc && (i_in.operation == OP_SEARCH);
        w_flags.at_end     = (r_v >= r_count);
        w_flags.over       = (r_try > {1'b0, r_num_colors});
        w_flags.fits       = !w_hit;
        w_flags.v_zero     = (r_v == '0);
        w_flags.slot_free  = !r_out_valid || o_out.ready;
        w_flags.last_out   = w_flags.slot_free && w_emit_last;
    end

    // Datapath actions
    always_comb begin
        n_v         = r_v;
        n_try       = r_try;
        n_count     = r_count;
        n_out_node  = r_out_node;
        n_out_color = r_out_color;
        n_out_found = r_out_found;
        n_out_last  = r_out_last;
        w_push      = 1'b0;
        case (w_act)
            A_START: begin
                n_v     = '0;
                n_count = w_clamped;
            end
            A_LOAD_C: begin
                n_try = {1'b0, r_color[w_vidx]} + TRY_W'(1);
            end
            A_PLACE: begin
                n_v = r_v + NODE_W'(1);
            end
            A_NEXT_C: begin
                n_try = r_try + TRY_W'(1);
            end
            A_BACK: begin
                n_v = r_v - NODE_W'(1);
            end
            A_ZERO_V: begin
                n_v = '0;
            end
            A_EMIT: begin
                if (w_flags.slot_free) begin
                    w_push      = 1'b1;
                    n_out_node  = r_v[OUTN_W-1:0];
                    n_out_color = r_color[w_vidx];
                    n_out_found = 1'b1;
                    n_out_last  = w_emit_last;
                    n_v         = r_v + NODE_W'(1);
                end
            end
            A_FAIL: begin
                if (w_flags.slot_free) begin
                    w_push      = 1'b1;
                    n_out_node  = '0;
                    n_out_color = '0;
                    n_out_found = 1'b0;
                    n_out_last  = 1'b1;
                end
            end
            default: ;
        endcase
        if (w_push) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_try       <= '0;
            r_count     <= NODE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_v         <= n_v;
            r_try       <= n_try;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_node  <= n_out_node;
        r_out_color <= n_out_color;
        r_out_found <= n_out_found;
        r_out_last  <= n_out_last;
    end

    // Adjacency rows: load when the row is in range
    always_ff @(posedge i_clk) begin
        if ((w_act == A_LOAD_ROW) && w_in_acc && (i_in.operation == OP_LOAD)
            && ({1'b0, i_in.row_index} < NODE_W'(ROWS))) begin
            r_adj[i_in.row_index[IDX_W-1:0]] <= i_in.row_bits;
        end
    end

    // Colour store: clear on start, place, drop on backtrack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                r_color[i] <= '0;
            end
        end else begin
            case (w_act)
                A_START: begin
                    for (int i = 0; i < ROWS; i++) begin
                        r_color[i] <= '0;
                    end
                end
                A_PLACE:          r_color[w_vidx] <= r_try[COLOR_W-1:0];
                A_BACK, A_CLEAR:  r_color[w_vidx] <= '0;
                default: ;
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.node  = r_out_node;
    assign o_out.color = r_out_color;
    assign o_out.found = r_out_found;
    assign o_out.last  = r_out_last;

    // Terms for the checks
    assign w_busy     = (w_step != S_IDLE);
    assign w_placing  = (w_act == A_PLACE);
    assign w_place_ok = (r_try != '0) && (r_try <= {1'b0, r_num_colors}) && !w_hit;
    assign w_fail_out = o_out.valid && !o_out.found;
    assign w_fail_ok  = (o_out.color == '0) && o_out.last && (o_out.node == '0);

    // Checks
    `GMC_ASSERT_HOLDS(a_v_in_range, i_clk, i_rst_n, w_busy, (r_v <= r_count), "node past count")
    `GMC_ASSERT_HOLDS(a_place_legal, i_clk, i_rst_n, w_placing, w_place_ok, "illegal colour")
    `GMC_ASSERT_HOLDS(a_push_free, i_clk, i_rst_n, w_push, w_flags.slot_free, "result lost")
    `GMC_ASSERT_HOLDS(a_fail_shape, i_clk, i_rst_n, w_fail_out, w_fail_ok, "bad failure report")
    `GMC_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, w_push, o_out.valid, "result not presented")

endmodule

`default_nettype wire
